// ----- src/gpsd_pkg.sv -----
// Shared types and constants for the glyph point stream decoder.
// No dependencies; imported by the top, gpsd_ctrl and gpsd_out (gpsd_mem does not use it).
`timescale 1ns / 1ps

package gpsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 7;
    localparam int FLAG_W  = 5;
    localparam int COORD_W = 16;
    localparam int IDX_W   = 6;

    // Bit positions in a stored flag entry
    localparam int F_ON     = 0;
    localparam int F_XSHORT = 1;
    localparam int F_YSHORT = 2;
    localparam int F_XSAME  = 3;
    localparam int F_YSAME  = 4;

    // Repeat bit in the raw flag byte
    localparam int B_REPEAT = 3;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_X    = 2'd1,
        PH_Y    = 2'd2
    } t_phase;

    typedef struct packed {
        logic                      glyph_done;
        logic [IDX_W-1:0]          idx;
        logic                      on_flag;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    // Sequencer -> result buffer
    typedef struct packed {
        logic   emit;    // new point produced this cycle
        logic   finish;  // current byte fully handled
        t_point pt;
    } t_res_ctl;

    // Result buffer -> sequencer
    typedef struct packed {
        logic can_accept;
        logic pend_valid;
    } t_out_stat;

endpackage

// ----- src/glyph_point_stream_decoder_top.sv -----
// Glyph point stream decoder top; uses gpsd_pkg, gpsd_mem, gpsd_ctrl, gpsd_out.
// A flag or coordinate byte is accepted and then walked in ST_ADV (a repeat count fills in ST_REP
// first); a high delta byte is only latched. No new byte is taken until the walk ends.
// Master-side stalls hold the walk, which waits on the registered read of the flag memory.
// A point passes through the held-point buffer and then the output register on its way out.
// Reset (i_rst_n, sync, active low) clears control and buffers, not the memories.
`timescale 1ns / 1ps

module glyph_point_stream_decoder_top
    import gpsd_pkg::*;
#(
    parameter int POINT_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: point count
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // byte stream in
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    // points out
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [39:0]        m_axis_tdata,   // [15:0] point_x, [31:16] point_y,
                                               // [37:32] point_index, [39:38] zero
    output logic               m_axis_tlast,   // run_end
    output logic [1:0]         m_axis_tuser    // [0] on-curve bit, [1] glyph_done
);

    localparam int CW = $clog2(POINT_DEPTH + 1);
    localparam int AW = $clog2(POINT_DEPTH);

    logic [CFG_W-1:0]   r_point_count;
    logic [CW-1:0]      w_n;

    logic [AW-1:0]      w_raddr;
    logic [AW-1:0]      w_waddr;
    logic               w_flag_we;
    logic [FLAG_W-1:0]  w_flag_wdata;
    logic [FLAG_W-1:0]  w_flag_q;
    logic               w_x_we;
    logic [COORD_W-1:0] w_x_wdata;
    logic [COORD_W-1:0] w_x_q;
    t_res_ctl           w_res;
    t_out_stat          w_stat;
    t_point             w_pt;

    // Point count register; write it only while the decoder is quiet (the block does not enforce this)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_point_count <= i_cfg_data;
        end
    end

    // Effective count: zero acts as one, above capacity clips to capacity
    always_comb begin
        if (r_point_count == '0) begin
            w_n = CW'(1);
        end else if (r_point_count > CFG_W'(POINT_DEPTH)) begin
            w_n = CW'(POINT_DEPTH);
        end else begin
            w_n = CW'(r_point_count);
        end
    end

    // Flag store: on, x-short, y-short, x-same, y-same per point
    gpsd_mem #(
        .WIDTH (FLAG_W),
        .DEPTH (POINT_DEPTH)
    ) u_flag_mem (
        .i_clk   (i_clk),
        .i_we    (w_flag_we),
        .i_waddr (w_waddr),
        .i_wdata (w_flag_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_flag_q)
    );

    // X store: absolute x per point, read back during the Y pass
    gpsd_mem #(
        .WIDTH (COORD_W),
        .DEPTH (POINT_DEPTH)
    ) u_x_mem (
        .i_clk   (i_clk),
        .i_we    (w_x_we),
        .i_waddr (w_waddr),
        .i_wdata (w_x_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_x_q)
    );

    gpsd_ctrl #(
        .POINT_DEPTH (POINT_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_n          (w_n),
        .i_byte_valid (s_axis_tvalid),
        .o_byte_ready (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_flag_q     (w_flag_q),
        .i_x_q        (w_x_q),
        .o_raddr      (w_raddr),
        .o_waddr      (w_waddr),
        .o_flag_we    (w_flag_we),
        .o_flag_wdata (w_flag_wdata),
        .o_x_we       (w_x_we),
        .o_x_wdata    (w_x_wdata),
        .o_res        (w_res),
        .i_stat       (w_stat)
    );

    // One point held back until we know whether it ends the byte's run
    gpsd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .o_stat  (w_stat),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_point (w_pt),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_pt.idx, w_pt.y, w_pt.x};
    assign m_axis_tuser = {w_pt.glyph_done, w_pt.on_flag};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------

    // Final point of a glyph always closes the run of its byte
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("glyph_done point without tlast");

    // A new byte is only taken once the held point has been flushed
    a_no_pend_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_stat.pend_valid)
        else $error("byte ready while a point is still held");

    // Emitting a point and closing a byte never coincide
    a_emit_finish_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.emit |-> !w_res.finish)
        else $error("emit and finish in the same cycle");

    // Output register comes up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

// ----- src/gpsd_mem.sv -----
// Synchronous single-write, single-read RAM with a registered read.
// Write data is forwarded when the read hits the entry being written. No deps.
`timescale 1ns / 1ps

module gpsd_mem #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/gpsd_ctrl.sv -----
// Byte sequencer: flag, X and Y phases, repeat fill and zero-byte walk.
// Drives the flag and X memories; depends on gpsd_pkg.
`timescale 1ns / 1ps

module gpsd_ctrl
    import gpsd_pkg::*;
#(
    parameter int POINT_DEPTH = 64,
    localparam int CW         = $clog2(POINT_DEPTH + 1),
    localparam int AW         = $clog2(POINT_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CW-1:0]       i_n,
    input  logic                i_byte_valid,
    output logic                o_byte_ready,
    input  logic [BYTE_W-1:0]   i_byte,
    input  logic [FLAG_W-1:0]   i_flag_q,
    input  logic [COORD_W-1:0]  i_x_q,
    output logic [AW-1:0]       o_raddr,
    output logic [AW-1:0]       o_waddr,
    output logic                o_flag_we,
    output logic [FLAG_W-1:0]   o_flag_wdata,
    output logic                o_x_we,
    output logic [COORD_W-1:0]  o_x_wdata,
    output t_res_ctl            o_res,
    input  t_out_stat           i_stat
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_REP  = 3'b010,
        ST_ADV  = 3'b100
    } t_state;

    t_state              r_state,    n_state;
    t_phase              r_phase,    n_phase;
    logic [CW-1:0]       r_cursor,   n_cursor;
    logic [CW-1:0]       r_rep_cnt,  n_rep_cnt;
    logic                r_rep_pend, n_rep_pend;
    logic [FLAG_W-1:0]   r_held,     n_held;
    logic                r_hi_pend,  n_hi_pend;
    logic [BYTE_W-1:0]   r_hi,       n_hi;
    logic [COORD_W-1:0]  r_rv,       n_rv;

    logic                w_lt_n;
    logic [CW-1:0]       w_cur_inc;
    logic [CFG_W-1:0]    w_cur7;
    logic [CW-1:0]       w_room;
    logic [BYTE_W-1:0]   w_room8;
    logic [BYTE_W-1:0]   w_k8;
    logic [CW-1:0]       w_k;
    logic [FLAG_W-1:0]   w_new_flag;
    logic                w_sh;
    logic                w_sm;
    logic                w_done;
    logic [COORD_W-1:0]  w_rv_new;

    assign w_lt_n     = r_cursor < i_n;
    assign w_cur_inc  = r_cursor + 1'b1;
    assign w_cur7     = CFG_W'(r_cursor);
    assign w_room     = w_lt_n ? (i_n - r_cursor) : '0;
    assign w_room8    = BYTE_W'(w_room);
    assign w_k8       = (i_byte < w_room8) ? i_byte : w_room8;
    assign w_k        = CW'(w_k8);
    assign w_new_flag = {i_byte[5:4], i_byte[2:0]};
    assign w_sh       = (r_phase == PH_X) ? i_flag_q[F_XSHORT] : i_flag_q[F_YSHORT];
    assign w_sm       = (r_phase == PH_X) ? i_flag_q[F_XSAME]  : i_flag_q[F_YSAME];

    assign o_byte_ready = (r_state == ST_IDLE);
    assign o_waddr      = r_cursor[AW-1:0];
    // Read the entry the cursor will point at next cycle
    assign o_raddr      = (n_cursor < CW'(POINT_DEPTH)) ? n_cursor[AW-1:0] : '0;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_cursor     = r_cursor;
        n_rep_cnt    = r_rep_cnt;
        n_rep_pend   = r_rep_pend;
        n_held       = r_held;
        n_hi_pend    = r_hi_pend;
        n_hi         = r_hi;
        n_rv         = r_rv;
        o_flag_we    = 1'b0;
        o_flag_wdata = w_new_flag;
        o_x_we       = 1'b0;
        o_x_wdata    = r_rv;
        w_done       = 1'b0;
        w_rv_new     = r_rv;

        o_res.emit          = 1'b0;
        o_res.finish        = 1'b0;
        o_res.pt.x          = i_x_q;
        o_res.pt.y          = r_rv;
        o_res.pt.on_flag    = i_flag_q[F_ON];
        o_res.pt.idx        = w_cur7[IDX_W-1:0];
        o_res.pt.glyph_done = (w_cur_inc == i_n);

        unique case (r_state)
            ST_IDLE: begin
                if (i_byte_valid) begin
                    case (r_phase) inside
                        PH_X, PH_Y: begin
                            if (!w_lt_n) begin
                                n_state = ST_ADV;
                            end else begin
                                if (w_sh) begin
                                    w_rv_new = w_sm ? (r_rv + COORD_W'(i_byte))
                                                    : (r_rv - COORD_W'(i_byte));
                                    w_done   = 1'b1;
                                end else if (r_hi_pend) begin
                                    w_rv_new  = r_rv + {r_hi, i_byte};
                                    n_hi_pend = 1'b0;
                                    w_done    = 1'b1;
                                end else begin
                                    n_hi      = i_byte;
                                    n_hi_pend = 1'b1;
                                end
                                if (w_done) begin
                                    n_rv = w_rv_new;
                                    if (r_phase == PH_X) begin
                                        o_x_we    = 1'b1;
                                        o_x_wdata = w_rv_new;
                                    end else begin
                                        o_res.emit = 1'b1;
                                        o_res.pt.y = w_rv_new;
                                    end
                                    n_cursor = w_cur_inc;
                                    n_state  = ST_ADV;
                                end
                            end
                        end
                        default: begin
                            // flag phase (unused phase code lands here too)
                            n_phase = PH_FLAG;
                            if (r_rep_pend) begin
                                if (w_k == '0) begin
                                    n_rep_pend = 1'b0;
                                    n_state    = ST_ADV;
                                end else begin
                                    n_rep_cnt = w_k;
                                    n_state   = ST_REP;
                                end
                            end else begin
                                if (w_lt_n) begin
                                    o_flag_we = 1'b1;
                                    n_cursor  = w_cur_inc;
                                    if (i_byte[B_REPEAT]) begin
                                        n_rep_pend = 1'b1;
                                        n_held     = w_new_flag;
                                    end
                                end
                                n_state = ST_ADV;
                            end
                        end
                    endcase
                end
            end
            ST_REP: begin
                o_flag_we    = 1'b1;
                o_flag_wdata = r_held;
                n_cursor     = w_cur_inc;
                n_rep_cnt    = r_rep_cnt - 1'b1;
                if (r_rep_cnt == CW'(1)) begin
                    n_rep_pend = 1'b0;
                    n_state    = ST_ADV;
                end
            end
            ST_ADV: begin
                if (i_stat.can_accept) begin
                    case (r_phase)
                        PH_X: begin
                            if (!w_lt_n) begin
                                n_phase  = PH_Y;
                                n_cursor = '0;
                                n_rv     = '0;
                            end else if (!i_flag_q[F_XSHORT] && i_flag_q[F_XSAME]) begin
                                o_x_we   = 1'b1;
                                n_cursor = w_cur_inc;
                            end else begin
                                o_res.finish = 1'b1;
                                n_state      = ST_IDLE;
                            end
                        end
                        PH_Y: begin
                            if (!w_lt_n) begin
                                n_phase      = PH_FLAG;
                                n_cursor     = '0;
                                n_rv         = '0;
                                o_res.finish = 1'b1;
                                n_state      = ST_IDLE;
                            end else if (!i_flag_q[F_YSHORT] && i_flag_q[F_YSAME]) begin
                                o_res.emit = 1'b1;
                                n_cursor   = w_cur_inc;
                            end else begin
                                o_res.finish = 1'b1;
                                n_state      = ST_IDLE;
                            end
                        end
                        default: begin
                            if (!r_rep_pend && !w_lt_n) begin
                                n_phase  = PH_X;
                                n_cursor = '0;
                                n_rv     = '0;
                            end else begin
                                o_res.finish = 1'b1;
                                n_state      = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_FLAG;
            r_cursor   <= '0;
            r_rep_cnt  <= '0;
            r_rep_pend <= 1'b0;
            r_held     <= '0;
            r_hi_pend  <= 1'b0;
            r_hi       <= '0;
            r_rv       <= '0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_cursor   <= n_cursor;
            r_rep_cnt  <= n_rep_cnt;
            r_rep_pend <= n_rep_pend;
            r_held     <= n_held;
            r_hi_pend  <= n_hi_pend;
            r_hi       <= n_hi;
            r_rv       <= n_rv;
        end
    end

endmodule

// ----- src/gpsd_out.sv -----
// Result buffer: holds the newest point until its last-of-byte mark is
// known, then moves it to the output register. Depends on gpsd_pkg.
`timescale 1ns / 1ps

module gpsd_out
    import gpsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_ctl  i_res,
    output t_out_stat o_stat,
    output logic      o_valid,
    input  logic      i_ready,
    output t_point    o_point,
    output logic      o_last
);

    logic   r_pend_valid;
    t_point r_pend;
    logic   r_out_valid;
    t_point r_out;
    logic   r_out_last;
    logic   w_out_free;
    logic   w_push;

    assign w_out_free        = !r_out_valid || i_ready;
    assign w_push            = r_pend_valid && (i_res.emit || i_res.finish);
    assign o_stat.can_accept = !r_pend_valid || w_out_free;
    assign o_stat.pend_valid = r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_res.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_res.finish) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out      <= r_pend;
            r_out_last <= i_res.finish;
        end
        if (i_res.emit) begin
            r_pend <= i_res.pt;
        end
    end

    assign o_valid = r_out_valid;
    assign o_point = r_out;
    assign o_last  = r_out_last;

endmodule
